/* design/grouped_softmax_silu_gate_defines.svh */
// Assertion macros for the top-level design file
`ifndef GROUPED_SOFTMAX_SILU_GATE_DEFINES_SVH
`define GROUPED_SOFTMAX_SILU_GATE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define GSSG_ASSERT_NOW(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("check failed");

// next-cycle implication
`define GSSG_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("check failed");

`endif

/* design/gssg_pkg.sv */
package gssg_pkg;

  localparam int GROUP_MAX_DEF = 64;
  // log2(e) in Q16
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  // quotient bits of the fractional divider (result up to 2^16)
  localparam int DIV_STEPS = 17;

  // 2^(-k/16) in Q16, k = 0..16
  function automatic logic [16:0] pow2_q16(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

/* design/grouped_softmax_silu_gate.sv */
// Elements load one per cycle when ready; the last of a group hands it to the normalizer.
// Normalizer: an exp sum pass over the group's elements, then one result per element,
// formed by two 17-step serial divisions and the shared exp sequence.
// Input stalls from the last element of a group until the group's last result is formed.
// Async reset (rst_ni low) empties the queue, clears count and overflow; max to -32768.
module grouped_softmax_silu_gate #(
  parameter int GROUP_MAX = gssg_pkg::GROUP_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [15:0] hidden_value, [31:16] gate_value
  input  logic        s_axis_tlast,  // last_of_group
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // [15:0] product_value, [31:16] share_value
  output logic        m_axis_tlast,  // last_of_run
  output logic        m_axis_tuser   // group_overflow
);

  `include "grouped_softmax_silu_gate_defines.svh"

  localparam int AW     = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1;
  localparam int CW     = $clog2(GROUP_MAX + 1);
  localparam int DESC_W = CW + 17;

  logic              desc_push, desc_full, desc_pop, desc_valid;
  logic [DESC_W-1:0] desc_in, desc_out;
  logic              group_done, front_hold;
  logic [AW-1:0]     rd_addr;
  logic [31:0]       rd_data;

  gssg_front #(.GROUP_MAX(GROUP_MAX), .AW(AW), .CW(CW), .DESC_W(DESC_W)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .hidden_i     (s_axis_tdata[15:0]),
    .gate_i       (s_axis_tdata[31:16]),
    .last_i       (s_axis_tlast),
    .desc_push_o  (desc_push),
    .desc_o       (desc_in),
    .desc_full_i  (desc_full),
    .group_done_i (group_done),
    .hold_o       (front_hold),
    .rd_addr_i    (rd_addr),
    .rd_data_o    (rd_data)
  );

  gssg_queue #(.W(DESC_W)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .data_i  (desc_in),
    .full_o  (desc_full),
    .pop_i   (desc_pop),
    .valid_o (desc_valid),
    .data_o  (desc_out)
  );

  gssg_back #(.GROUP_MAX(GROUP_MAX), .AW(AW), .CW(CW), .DESC_W(DESC_W)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (desc_valid),
    .desc_i       (desc_out),
    .desc_pop_o   (desc_pop),
    .group_done_o (group_done),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .product_o    (m_axis_tdata[15:0]),
    .share_o      (m_axis_tdata[31:16]),
    .last_o       (m_axis_tlast),
    .overflow_o   (m_axis_tuser)
  );

  `GSSG_ASSERT_NOW(a_queue_no_overrun, desc_push, !desc_full)
  `GSSG_ASSERT_NOW(a_hold_blocks_input, front_hold, !s_axis_tready)
  `GSSG_ASSERT_NEXT(a_done_releases_front, group_done, !front_hold)

endmodule

/* design/gssg_div.sv */
// Restoring divider: q = floor(x * 2^16 / d), for x <= d, one quotient bit per cycle
module gssg_div #(
  parameter int DW = 23
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] x_i,
  input  logic [DW-1:0] d_i,
  output logic          done_o,
  output logic [16:0]   q_o
);

  localparam int SW = $clog2(gssg_pkg::DIV_STEPS);

  logic [DW:0]   rem_q;
  logic [DW-1:0] d_q;
  logic [16:0]   q_q;
  logic [SW-1:0] step_q;
  logic          busy_q, done_q;
  logic          ge;
  logic [DW:0]   rem_n;

  assign ge    = rem_q >= {1'b0, d_q};
  assign rem_n = ge ? rem_q - {1'b0, d_q} : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (step_q == SW'(gssg_pkg::DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, x_i};
      d_q   <= d_i;
      q_q   <= '0;
    end else if (busy_q) begin
      rem_q <= {rem_n[DW-1:0], 1'b0};
      q_q   <= {q_q[15:0], ge};
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

/* design/gssg_front.sv */
// Loads one group: element store, running max, count, overflow flag
module gssg_front #(
  parameter int GROUP_MAX = gssg_pkg::GROUP_MAX_DEF,
  parameter int AW        = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1,
  parameter int CW        = $clog2(GROUP_MAX + 1),
  parameter int DESC_W    = CW + 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [15:0]       hidden_i,
  input  logic [15:0]       gate_i,
  input  logic              last_i,
  output logic              desc_push_o,
  output logic [DESC_W-1:0] desc_o,     // {overflow, max, count}
  input  logic              desc_full_i,
  input  logic              group_done_i,
  output logic              hold_o,
  input  logic [AW-1:0]     rd_addr_i,
  output logic [31:0]       rd_data_o   // {gate, hidden}
);

  logic [31:0]        mem [GROUP_MAX];
  logic [31:0]        rd_data_q;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic signed [15:0] max_q, max_d;
  logic               ovf_q, ovf_d;
  logic               hold_q;
  logic               accept, full;

  assign in_ready_o = !hold_q && !desc_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = cnt_q == CW'(GROUP_MAX);

  always_comb begin
    cnt_d = cnt_q;
    max_d = max_q;
    ovf_d = ovf_q;
    if (full) begin
      ovf_d = 1'b1;
    end else begin
      cnt_d = cnt_q + 1'b1;
      if ($signed(hidden_i) > max_q) max_d = $signed(hidden_i);
    end
  end

  assign desc_push_o = accept && last_i;
  assign desc_o      = {ovf_d, max_d, cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      max_q  <= 16'sh8000;
      ovf_q  <= 1'b0;
      hold_q <= 1'b0;
    end else begin
      if (accept) begin
        if (last_i) begin
          cnt_q  <= '0;
          max_q  <= 16'sh8000;
          ovf_q  <= 1'b0;
          hold_q <= 1'b1;
        end else begin
          cnt_q <= cnt_d;
          max_q <= max_d;
          ovf_q <= ovf_d;
        end
      end else if (group_done_i) begin
        hold_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !full) mem[cnt_q[AW-1:0]] <= {gate_i, hidden_i};
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
  assign hold_o    = hold_q;

endmodule

/* design/gssg_queue.sv */
// Two-entry queue of group descriptors
module gssg_queue #(
  parameter int W = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] slot_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= data_i;
  end

  assign full_o  = fill_q == 2'd2;
  assign valid_o = fill_q != 2'd0;
  assign data_o  = slot_q[rd_q];

endmodule

/* design/gssg_back.sv */
// Normalizes one stored group: exp sum pass, then per element share, sigmoid and product
module gssg_back #(
  parameter int GROUP_MAX = gssg_pkg::GROUP_MAX_DEF,
  parameter int AW        = (GROUP_MAX > 1) ? $clog2(GROUP_MAX) : 1,
  parameter int CW        = $clog2(GROUP_MAX + 1),
  parameter int DESC_W    = CW + 17,
  parameter int SUM_W     = 17 + $clog2(GROUP_MAX),
  parameter int DW        = (SUM_W > 18) ? SUM_W : 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              desc_valid_i,
  input  logic [DESC_W-1:0] desc_i,
  output logic              desc_pop_o,
  output logic              group_done_o,
  output logic [AW-1:0]     rd_addr_o,
  input  logic [31:0]       rd_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       product_o,
  output logic [15:0]       share_o,
  output logic              last_o,
  output logic              overflow_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_LATCH, S_EXP1, S_EXP2, S_EXP3, S_AFTER,
    S_DIV_SHARE, S_DIV_SIG, S_MUL1, S_MUL2, S_OUT
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      cnt_q, k_q;
  logic signed [15:0] max_q;
  logic               ovf_q, pass_q, gate_q;
  logic [SUM_W-1:0]   sum_q;
  logic signed [15:0] g_q;
  logic [15:0]        m_q, a_q;
  logic [16:0]        t_q, pi_q, e_q, ek_q, eg_q, share_q, sig_q;
  logic [4:0]         n_q;
  logic [11:0]        dr_q;
  logic [32:0]        p1_q;
  logic [49:0]        p2_q;
  logic               last_k;

  logic               div_start, div_done;
  logic [DW-1:0]      div_x, div_d;
  logic [16:0]        div_q;

  logic [16:0]        lat_diff;
  logic [16:0]        abs_g;
  logic [32:0]        t_full;
  logic [16:0]        p_lo, p_hi, v;
  logic [19:0]        dr_full;
  logic [17:0]        mag;
  logic               out_free;
  logic               out_set;
  logic [15:0]        prod_sat;

  assign last_k   = k_q == cnt_q - 1'b1;
  assign out_free = !out_valid_o || out_ready_i;
  assign out_set  = state_q == S_OUT && out_free;

  assign lat_diff = 17'($signed(max_q) - $signed(rd_data_i[15:0]));
  assign abs_g    = rd_data_i[31] ? 17'(-$signed({rd_data_i[31], rd_data_i[31:16]}))
                                  : {1'b0, rd_data_i[31:16]};
  assign t_full   = {17'd0, m_q} * {16'd0, gssg_pkg::LOG2E_Q16};
  assign p_lo     = gssg_pkg::pow2_q16({1'b0, t_q[11:8]});
  assign p_hi     = gssg_pkg::pow2_q16({1'b0, t_q[11:8]} + 5'd1);
  assign dr_full  = 20'(p_lo - p_hi) * {12'd0, t_q[7:0]};
  assign v        = pi_q - {5'd0, dr_q};

  assign mag = p2_q[49:32];
  always_comb begin
    if (g_q < 0) begin
      prod_sat = (mag > 18'd32768) ? 16'h8000 : 16'(-mag);
    end else begin
      prod_sat = (mag > 18'd32767) ? 16'h7FFF : mag[15:0];
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_x     = DW'(ek_q);
    div_d     = DW'(sum_q);
    if (state_q == S_AFTER && pass_q && gate_q) begin
      div_start = 1'b1;
    end else if (state_q == S_DIV_SHARE && div_done) begin
      div_start = 1'b1;
      div_x     = g_q < 0 ? DW'(eg_q) : DW'(18'd65536);
      div_d     = DW'(18'd65536 + {1'b0, eg_q});
    end
  end

  gssg_div #(.DW(DW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .x_i     (div_x),
    .d_i     (div_d),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  assign desc_pop_o = state_q == S_IDLE && desc_valid_i;
  assign rd_addr_o  = k_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_o  <= 1'b0;
      group_done_o <= 1'b0;
      pass_q       <= 1'b0;
      gate_q       <= 1'b0;
      k_q          <= '0;
    end else begin
      group_done_o <= out_set && last_k;
      if (out_set) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (desc_valid_i) begin
            cnt_q   <= desc_i[CW-1:0];
            max_q   <= desc_i[CW+15:CW];
            ovf_q   <= desc_i[CW+16];
            k_q     <= '0;
            sum_q   <= '0;
            pass_q  <= 1'b0;
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_LATCH;
        S_LATCH: begin
          g_q     <= rd_data_i[31:16];
          a_q     <= abs_g[15:0];
          m_q     <= lat_diff[15:0];
          gate_q  <= 1'b0;
          state_q <= S_EXP1;
        end
        S_EXP1: begin
          t_q     <= t_full[32:16];
          state_q <= S_EXP2;
        end
        S_EXP2: begin
          n_q     <= t_q[16:12];
          pi_q    <= p_lo;
          dr_q    <= dr_full[19:8];
          state_q <= S_EXP3;
        end
        S_EXP3: begin
          e_q     <= (n_q >= 5'd17) ? 17'd0 : (v >> n_q);
          state_q <= S_AFTER;
        end
        S_AFTER: begin
          if (!pass_q) begin
            sum_q <= sum_q + SUM_W'(e_q);
            if (last_k) begin
              pass_q <= 1'b1;
              k_q    <= '0;
            end else begin
              k_q <= k_q + 1'b1;
            end
            state_q <= S_RD;
          end else if (!gate_q) begin
            ek_q    <= e_q;
            m_q     <= a_q;
            gate_q  <= 1'b1;
            state_q <= S_EXP1;
          end else begin
            eg_q    <= e_q;
            state_q <= S_DIV_SHARE;
          end
        end
        S_DIV_SHARE: begin
          if (div_done) begin
            share_q <= div_q;
            state_q <= S_DIV_SIG;
          end
        end
        S_DIV_SIG: begin
          if (div_done) begin
            sig_q   <= div_q;
            state_q <= S_MUL1;
          end
        end
        S_MUL1: begin
          p1_q    <= {17'd0, a_q} * {16'd0, sig_q};
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          p2_q    <= {17'd0, p1_q} * {33'd0, share_q};
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            product_o   <= prod_sat;
            share_o     <= share_q[16] ? 16'hFFFF : share_q[15:0];
            last_o      <= last_k;
            overflow_o  <= ovf_q;
            if (last_k) begin
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
